// ===== rtl/hsv_to_rgb_fixed_assert.svh =====
// Assertion macros for the checker file of the colour converter.
// No dependencies; clock and reset are taken as clk_i and rst_ni.
`ifndef HSV_TO_RGB_FIXED_ASSERT_SVH
`define HSV_TO_RGB_FIXED_ASSERT_SVH

// Clocked assertion, disabled while in reset, generic message
`define HSVRGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsvrgb assertion failed");

// Clocked assertion with a caller-supplied message
`define HSVRGB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned ChanW = 16;
  localparam int unsigned WordW = 32;
  localparam logic [ChanW-1:0] Full16 = 16'hFFFF;

  // Hue sector after scaling by six
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  typedef struct packed {
    logic [WordW-1:0] hue;
    logic [WordW-1:0] saturation;
    logic [WordW-1:0] brightness;
  } hsv_beat_t;

  typedef struct packed {
    logic [WordW-1:0] red;
    logic [WordW-1:0] green;
    logic [WordW-1:0] blue;
  } rgb_beat_t;

  // Copy a channel into both halves of an output word
  function automatic logic [WordW-1:0] replicate(input logic [ChanW-1:0] c);
    return {c, c};
  endfunction

endpackage

// ===== rtl/hsvrgb_mulhi.sv =====
// Unsigned 16x16 multiply keeping the upper half of the product.
// Depends on hsvrgb_pkg.
module hsvrgb_mulhi
  import hsvrgb_pkg::*;
(
  input  logic [ChanW-1:0] a_i,
  input  logic [ChanW-1:0] b_i,
  output logic [ChanW-1:0] p_o
);

  logic [2*ChanW-1:0] prod;

  // Full product, truncated to the high half
  assign prod = a_i * b_i;
  assign p_o  = prod[2*ChanW-1:ChanW];

endmodule

// ===== rtl/hsv_to_rgb_fixed.sv =====
// Top level of the fixed-point HSV to RGB converter.
// Depends on hsvrgb_pkg and hsvrgb_mulhi.

// Converts one hue/saturation/brightness beat per clock into red/green/blue
// when the output side does not stall. Only bits 31..16 of each input word
// are used; a zero saturation is taken as one and a hue of all ones wraps to
// zero. Each 16-bit channel comes out copied into both halves of its 32-bit
// word. The pipeline is an input stage, two ranks of 16x16 multipliers and a
// selection/output stage, each registered. Back-pressure stalls only the
// stages that are full, so bubbles are squeezed out.
module hsv_to_rgb_fixed
  import hsvrgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hsv_beat_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rgb_beat_t out_data_o
);

  // stage valids and enables
  logic vld1_q, vld2_q, vld3_q, vld_out_q;
  logic en1, en2, en3, en_out;

  // stage 1: clamped inputs, sector and fraction
  logic [ChanW-1:0] h_in, s_in;
  logic [ChanW+2:0] h6;
  sector_e          sec1_q;
  logic [ChanW-1:0] frac1_q, s1_q, v1_q;

  // stage 2: first multiplier rank
  sector_e          sec2_q;
  logic [ChanW-1:0] v2_q, w2_q, sf2_q, sfi2_q;
  logic [ChanW-1:0] sf_d, sfi_d, w_d;

  // stage 3: second multiplier rank
  sector_e          sec3_q;
  logic [ChanW-1:0] v3_q, w3_q, q3_q, t3_q;
  logic [ChanW-1:0] q_d, t_d;

  // output register
  rgb_beat_t out_d, out_q;

  // a stage moves when it is empty or its successor moves
  assign en_out     = !vld_out_q || out_ready_i;
  assign en3        = !vld3_q || en_out;
  assign en2        = !vld2_q || en3;
  assign en1        = !vld1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld_out_q <= 1'b0;
    end else begin
      if (en1)    vld1_q    <= in_valid_i;
      if (en2)    vld2_q    <= vld1_q;
      if (en3)    vld3_q    <= vld2_q;
      if (en_out) vld_out_q <= vld3_q;
    end
  end

  // input clamps and hue times six
  always_comb begin
    h_in = in_data_i.hue[WordW-1:ChanW];
    s_in = in_data_i.saturation[WordW-1:ChanW];
    if (h_in == Full16) h_in = '0;
    if (s_in == '0)     s_in = ChanW'(1);
    h6 = {1'b0, h_in, 2'b00} + {2'b00, h_in, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q  <= sector_e'(h6[ChanW+2:ChanW]);
      frac1_q <= h6[ChanW-1:0];
      s1_q    <= s_in;
      v1_q    <= in_data_i.brightness[WordW-1:ChanW];
    end
  end

  // first rank: S*f, S*(1-f), V*(1-S)
  hsvrgb_mulhi u_mul_sf  (.a_i(s1_q), .b_i(frac1_q),          .p_o(sf_d));
  hsvrgb_mulhi u_mul_sfi (.a_i(s1_q), .b_i(Full16 - frac1_q), .p_o(sfi_d));
  hsvrgb_mulhi u_mul_w   (.a_i(v1_q), .b_i(Full16 - s1_q),    .p_o(w_d));

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sec2_q <= sec1_q;
      v2_q   <= v1_q;
      w2_q   <= w_d;
      sf2_q  <= sf_d;
      sfi2_q <= sfi_d;
    end
  end

  // second rank: q and t
  hsvrgb_mulhi u_mul_q (.a_i(v2_q), .b_i(Full16 - sf2_q),  .p_o(q_d));
  hsvrgb_mulhi u_mul_t (.a_i(v2_q), .b_i(Full16 - sfi2_q), .p_o(t_d));

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sec3_q <= sec2_q;
      v3_q   <= v2_q;
      w3_q   <= w2_q;
      q3_q   <= q_d;
      t3_q   <= t_d;
    end
  end

  // sector decode onto the channels
  always_comb begin
    unique case (sec3_q)
      SecRed: begin
        out_d.red   = replicate(v3_q);
        out_d.green = replicate(t3_q);
        out_d.blue  = replicate(w3_q);
      end
      SecYellow: begin
        out_d.red   = replicate(q3_q);
        out_d.green = replicate(v3_q);
        out_d.blue  = replicate(w3_q);
      end
      SecGreen: begin
        out_d.red   = replicate(w3_q);
        out_d.green = replicate(v3_q);
        out_d.blue  = replicate(t3_q);
      end
      SecCyan: begin
        out_d.red   = replicate(w3_q);
        out_d.green = replicate(q3_q);
        out_d.blue  = replicate(v3_q);
      end
      SecBlue: begin
        out_d.red   = replicate(t3_q);
        out_d.green = replicate(w3_q);
        out_d.blue  = replicate(v3_q);
      end
      default: begin
        out_d.red   = replicate(v3_q);
        out_d.green = replicate(w3_q);
        out_d.blue  = replicate(q3_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_out) out_q <= out_d;
  end

  assign out_valid_o = vld_out_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/hsvrgb_chk.sv =====
// Port-level checker for hsv_to_rgb_fixed, bound to the top level.
// Depends on hsvrgb_pkg and hsv_to_rgb_fixed_assert.svh.
`include "hsv_to_rgb_fixed_assert.svh"

module hsvrgb_chk
  import hsvrgb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input hsv_beat_t in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input rgb_beat_t out_data_o
);

  // a stalled output beat holds
  `HSVRGB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // input only refused when the whole pipe is backed up
  `HSVRGB_ASSERT_MSG(a_in_stall, !in_ready_o |-> out_valid_o && !out_ready_i, "spurious input stall")

  // every channel word carries the same value in both halves
  `HSVRGB_ASSERT(a_repl, out_valid_o |-> out_data_o.red[31:16] == out_data_o.red[15:0] && out_data_o.green[31:16] == out_data_o.green[15:0] && out_data_o.blue[31:16] == out_data_o.blue[15:0])

  // black input comes out black while the output side stays ready
  `HSVRGB_ASSERT_MSG(a_black, in_valid_i && in_ready_o && in_data_i.brightness[31:16] == 16'h0 ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o && out_data_o.red == '0 && out_data_o.green == '0 && out_data_o.blue == '0, "black beat lost or wrong")

endmodule

bind hsv_to_rgb_fixed hsvrgb_chk u_hsvrgb_chk (.*);
